// ===== design/dpd_pkg.sv =====
// ============================================================================
// dpd_pkg: shared types and constants for the debug packet deframer
// Character codes, token and result encodings, and default parameters.
// ============================================================================
package dpd_pkg;

    // Protocol characters
    localparam logic [7:0] CHAR_START  = 8'h24;  // '$'
    localparam logic [7:0] CHAR_END    = 8'h23;  // '#'
    localparam logic [7:0] CHAR_ESCAPE = 8'h7D;  // '}'
    localparam logic [7:0] CHAR_RUN    = 8'h2A;  // '*'
    localparam logic [7:0] CHAR_ACK    = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_NAK    = 8'h2D;  // '-'
    localparam logic [7:0] ESCAPE_XOR  = 8'h20;
    localparam logic [7:0] RUN_BIAS    = 8'd29;

    // Default parameters
    localparam int PACKET_CAPACITY_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF     = 2;

    // Byte class decided by the front end
    typedef enum logic [2:0] {
        CLS_DATA,
        CLS_START,
        CLS_END,
        CLS_ESCAPE,
        CLS_RUN,
        CLS_ACK,
        CLS_NAK
    } cls_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_PAYLOAD,
        KIND_ACCEPT,
        KIND_BAD_SUM,
        KIND_OVERFLOW,
        KIND_ACK,
        KIND_NAK
    } kind_t;

    // Reply characters
    typedef enum logic [1:0] {
        REPLY_NONE,
        REPLY_ACK,
        REPLY_NAK
    } reply_t;

    // Classified byte passed from front to back
    typedef struct packed {
        cls_t       cls;
        logic [7:0] data;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic [7:0] run_count;   // count byte minus bias, zero if at or below
    } token_t;

endpackage

// ===== design/dpd_ram_queue.sv =====
// ============================================================================
// dpd_ram_queue: short token queue between front and back
// Register-based FIFO; full and empty flags come straight from the count.
// ============================================================================
module dpd_ram_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/dpd_front.sv =====
// ============================================================================
// dpd_front: input acceptance and byte classification
// Tags each received byte with its class, hex value and run count.
// ============================================================================
module dpd_front (
    input  logic            rx_valid,
    output logic            rx_stall,
    input  logic [7:0]      rx_byte,
    input  logic            q_full,
    output logic            push,
    output dpd_pkg::token_t push_token
);

    import dpd_pkg::*;

    cls_t       cls;
    logic       hex_ok;
    logic [3:0] hex_val;

    // Handshake: take a transaction whenever the queue has room
    assign rx_stall = q_full;
    assign push     = rx_valid && !q_full;

    // Class decode
    always_comb
    begin
        unique case (rx_byte)
            CHAR_START:  cls = CLS_START;
            CHAR_END:    cls = CLS_END;
            CHAR_ESCAPE: cls = CLS_ESCAPE;
            CHAR_RUN:    cls = CLS_RUN;
            CHAR_ACK:    cls = CLS_ACK;
            CHAR_NAK:    cls = CLS_NAK;
            default:     cls = CLS_DATA;
        endcase
    end

    // Hex digit decode
    always_comb
    begin
        hex_ok  = 1'b0;
        hex_val = 4'd0;
        if (rx_byte >= "0" && rx_byte <= "9")
        begin
            hex_ok  = 1'b1;
            hex_val = 4'(rx_byte - "0");
        end
        else if (rx_byte >= "a" && rx_byte <= "f")
        begin
            hex_ok  = 1'b1;
            hex_val = 4'(rx_byte - "a" + 8'd10);
        end
        else if (rx_byte >= "A" && rx_byte <= "F")
        begin
            hex_ok  = 1'b1;
            hex_val = 4'(rx_byte - "A" + 8'd10);
        end
    end

    assign push_token.cls       = cls;
    assign push_token.data      = rx_byte;
    assign push_token.hex_ok    = hex_ok;
    assign push_token.hex_val   = hex_val;
    assign push_token.run_count = (rx_byte > RUN_BIAS) ? rx_byte - RUN_BIAS : 8'd0;

endmodule

// ===== design/dpd_back.sv =====
// ============================================================================
// dpd_back: packet state machine and result register
// Consumes classified tokens, tracks checksum and length, emits results.
// ============================================================================
module dpd_back #(
    parameter int PACKET_CAPACITY = dpd_pkg::PACKET_CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic            q_empty,
    input  dpd_pkg::token_t q_token,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      kind,
    output logic [7:0]      data_byte,
    output logic [7:0]      repeat_count,
    output logic [10:0]     packet_length,
    output logic [1:0]      reply
);

    import dpd_pkg::*;

    localparam int LW = $clog2(PACKET_CAPACITY + 1);
    localparam int CW = (LW > 8) ? LW : 8;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_RUN,
        PH_HI,
        PH_LO
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [7:0]    sum_reg, sum_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    prev_reg, prev_next;
    logic [3:0]    hi_reg, hi_next;
    logic          dbad_reg, dbad_next;
    logic          no_ack_reg;

    logic          out_valid_reg, out_valid_next;
    kind_t         kind_reg, kind_next;
    logic [7:0]    data_reg, data_next;
    logic [7:0]    rep_reg, rep_next;
    logic [10:0]   plen_reg, plen_next;
    reply_t        reply_reg, reply_next;

    // Emit helper signals
    logic          emit_req;
    logic [7:0]    emit_byte;
    logic [7:0]    emit_n;
    logic [CW-1:0] room_w;
    logic [CW-1:0] take_w;
    logic          sum_bad;

    // Pop when a token waits and the result register is free or draining
    assign pop = !q_empty && (!out_valid_reg || !out_stall);

    assign room_w  = CW'(LW'(PACKET_CAPACITY) - len_reg);
    assign take_w  = (CW'(emit_n) > room_w) ? room_w : CW'(emit_n);
    assign sum_bad = dbad_reg || !q_token.hex_ok || ({hi_reg, q_token.hex_val} != sum_reg);

    // Packet state machine
    always_comb
    begin
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        prev_next      = prev_reg;
        hi_next        = hi_reg;
        dbad_next      = dbad_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        data_next      = data_reg;
        rep_next       = rep_reg;
        plen_next      = plen_reg;
        reply_next     = reply_reg;
        emit_req       = 1'b0;
        emit_byte      = q_token.data;
        emit_n         = 8'd1;

        if (pop)
        begin
            out_valid_next = 1'b0;
            if (q_token.cls == CLS_START)
            begin
                phase_next = PH_BODY;
                sum_next   = '0;
                len_next   = '0;
                ovf_next   = 1'b0;
                prev_next  = '0;
                hi_next    = '0;
                dbad_next  = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_BODY:
                    begin
                        if (q_token.cls == CLS_END)
                        begin
                            phase_next = PH_HI;
                        end
                        else
                        begin
                            sum_next = sum_reg + q_token.data;
                            if (q_token.cls == CLS_ESCAPE)
                            begin
                                phase_next = PH_ESC;
                            end
                            else if (q_token.cls == CLS_RUN)
                            begin
                                phase_next = PH_RUN;
                            end
                            else
                            begin
                                prev_next = q_token.data;
                                emit_req  = 1'b1;
                            end
                        end
                    end
                    PH_ESC:
                    begin
                        if (q_token.cls == CLS_END)
                        begin
                            phase_next = PH_HI;
                        end
                        else
                        begin
                            sum_next   = sum_reg + q_token.data;
                            phase_next = PH_BODY;
                            prev_next  = q_token.data ^ ESCAPE_XOR;
                            emit_byte  = q_token.data ^ ESCAPE_XOR;
                            emit_req   = 1'b1;
                        end
                    end
                    PH_RUN:
                    begin
                        if (q_token.cls == CLS_END)
                        begin
                            phase_next = PH_HI;
                        end
                        else
                        begin
                            sum_next   = sum_reg + q_token.data;
                            phase_next = PH_BODY;
                            emit_byte  = prev_reg;
                            emit_n     = q_token.run_count;
                            emit_req   = (q_token.run_count != 8'd0);
                        end
                    end
                    PH_HI:
                    begin
                        dbad_next  = !q_token.hex_ok;
                        hi_next    = q_token.hex_ok ? q_token.hex_val : 4'd0;
                        phase_next = PH_LO;
                    end
                    PH_LO:
                    begin
                        phase_next     = PH_IDLE;
                        out_valid_next = 1'b1;
                        data_next      = '0;
                        rep_next       = '0;
                        plen_next      = 11'(len_reg);
                        if (no_ack_reg)
                        begin
                            kind_next  = ovf_reg ? KIND_OVERFLOW : KIND_ACCEPT;
                            reply_next = REPLY_NONE;
                        end
                        else if (sum_bad)
                        begin
                            kind_next  = KIND_BAD_SUM;
                            reply_next = REPLY_NAK;
                        end
                        else
                        begin
                            kind_next  = ovf_reg ? KIND_OVERFLOW : KIND_ACCEPT;
                            reply_next = REPLY_ACK;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        data_next  = '0;
                        rep_next   = '0;
                        plen_next  = '0;
                        reply_next = REPLY_NONE;
                        if (q_token.cls == CLS_ACK)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_ACK;
                        end
                        else if (q_token.cls == CLS_NAK)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_NAK;
                        end
                    end
                endcase
            end

            // Payload emit, cut to the room left
            if (emit_req)
            begin
                if (CW'(emit_n) > room_w)
                begin
                    ovf_next = 1'b1;
                end
                if (take_w != '0)
                begin
                    len_next       = len_reg + LW'(take_w);
                    out_valid_next = 1'b1;
                    kind_next      = KIND_PAYLOAD;
                    data_next      = emit_byte;
                    rep_next       = 8'(take_w);
                    plen_next      = '0;
                    reply_next     = REPLY_NONE;
                end
            end
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            sum_reg       <= '0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            prev_reg      <= '0;
            hi_reg        <= '0;
            dbad_reg      <= 1'b0;
            no_ack_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_PAYLOAD;
            data_reg      <= '0;
            rep_reg       <= '0;
            plen_reg      <= '0;
            reply_reg     <= REPLY_NONE;
        end
        else
        begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            prev_reg      <= prev_next;
            hi_reg        <= hi_next;
            dbad_reg      <= dbad_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            data_reg      <= data_next;
            rep_reg       <= rep_next;
            plen_reg      <= plen_next;
            reply_reg     <= reply_next;
            if (cfg_we)
            begin
                no_ack_reg <= cfg_wdata;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign data_byte     = data_reg;
    assign repeat_count  = rep_reg;
    assign packet_length = plen_reg;
    assign reply         = reply_reg;

    // Checks
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(PACKET_CAPACITY))
        else $error("decoded length beyond capacity");

    a_payload_rep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_PAYLOAD) |-> (rep_reg != 8'd0))
        else $error("payload result with zero repeat count");

    a_reply_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_PAYLOAD || kind_reg == KIND_ACK ||
                           kind_reg == KIND_NAK)) |-> (reply_reg == REPLY_NONE))
        else $error("reply on a non-verdict result");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_token.cls == CLS_START) |=>
            (phase_reg == PH_BODY && len_reg == '0 && sum_reg == '0 && !ovf_reg))
        else $error("start character did not open a fresh packet");

endmodule

// ===== design/debug_packet_deframer_top.sv =====
// ============================================================================
// debug_packet_deframer_top: receive-side deframer for the debug serial link
// Decodes packets, escapes and runs; reports payload, verdicts, ack and nak.
// ============================================================================
//
//  Channel   Handshake              Payload
//  -------   ---------------------  -----------------------------------------
//  in        in_valid / in_stall    rx_byte
//  out       out_valid / out_stall  kind, data_byte, repeat_count,
//                                   packet_length, reply
//  cfg       cfg_we                 cfg_wdata (no_ack_mode)
//
//  One byte per cycle sustained while out_stall is low; a result is
//  registered: the queue is written at the accepting edge, and the back end
//  moves the byte into the result register when it pops it from the queue.
//  The token queue holds QUEUE_DEPTH bytes; in_stall rises only when it fills.
//  Reset is asynchronous, active low; it closes any packet and clears no-ack.
//  out_stall holds a valid result in its register; the back end then stops popping.
//
module debug_packet_deframer_top #(
    parameter int PACKET_CAPACITY = dpd_pkg::PACKET_CAPACITY_DEF,
    parameter int QUEUE_DEPTH     = dpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  repeat_count,
    output logic [10:0] packet_length,
    output logic [1:0]  reply
);

    import dpd_pkg::*;

    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    token_t push_token;
    token_t pop_token;

    // Front end: accept and classify
    dpd_front u_front (
        .rx_valid   (in_valid),
        .rx_stall   (in_stall),
        .rx_byte    (rx_byte),
        .q_full     (q_full),
        .push       (push),
        .push_token (push_token)
    );

    // Token queue
    dpd_ram_queue #(
        .WIDTH ($bits(token_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_token),
        .full    (q_full),
        .rd_en   (pop),
        .rd_data (pop_token),
        .empty   (q_empty)
    );

    // Back end: packet state and results
    dpd_back #(
        .PACKET_CAPACITY (PACKET_CAPACITY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_empty       (q_empty),
        .q_token       (pop_token),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .data_byte     (data_byte),
        .repeat_count  (repeat_count),
        .packet_length (packet_length),
        .reply         (reply)
    );

endmodule

// ===== bench/deframer_check.sv =====
`timescale 1ns / 100ps
// ============================================================================
// deframer_check: result predictor and comparator for the packet deframer
// Follows every byte the deframer accepts with its own copy of the framing
// state, queues the result each byte should cause, and checks each result
// the deframer hands over against the oldest queued one, field by field.
// ============================================================================
module deframer_check #(
    parameter int CAPACITY = dpd_pkg::PACKET_CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  repeat_count,
    input  logic [10:0] packet_length,
    input  logic [1:0]  reply,
    output int          fail_count,
    output int          results_owed
);

    import dpd_pkg::*;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_BODY,
        ST_ESCAPE,
        ST_COUNT,
        ST_SUM_HI,
        ST_SUM_LO
    } rx_state_t;

    typedef struct {
        kind_t       kind;
        logic [7:0]  data;
        logic [7:0]  copies;
        logic [10:0] length;
        reply_t      reply;
    } deframe_result_t;

    // Framing state shadow
    rx_state_t   rx_state;
    logic [7:0]  frame_sum;
    int          decoded_len;
    logic        len_overflow;
    logic [7:0]  last_byte;
    logic [3:0]  sum_hi;
    logic        sum_hi_bad;
    logic        no_ack;

    deframe_result_t pending_results[$];
    int              mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // -1 for anything that is not a hex digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    // n copies of b, cut to the room left in the packet
    function automatic bit emit_copies(input logic [7:0] b, input int n,
                                       output deframe_result_t r);
        int room;
        int take;
        r = '{KIND_PAYLOAD, 8'h00, 8'h00, 11'd0, REPLY_NONE};
        room = (decoded_len < CAPACITY) ? CAPACITY - decoded_len : 0;
        take = n;
        if (n == 0) return 1'b0;
        if (take > room)
        begin
            take = room;
            len_overflow = 1'b1;
        end
        if (take == 0) return 1'b0;
        decoded_len += take;
        r.data   = b;
        r.copies = 8'(take);
        return 1'b1;
    endfunction

    // Advances the framing state by one byte; returns 1 when a result is due
    function automatic bit decode_rx_byte(input logic [7:0] c,
                                          output deframe_result_t r);
        int   nib;
        logic mismatch;
        r = '{KIND_PAYLOAD, 8'h00, 8'h00, 11'd0, REPLY_NONE};

        // start character reopens a packet from any state
        if (c == CHAR_START)
        begin
            rx_state     = ST_BODY;
            frame_sum    = 8'h00;
            decoded_len  = 0;
            len_overflow = 1'b0;
            last_byte    = 8'h00;
            sum_hi_bad   = 1'b0;
            sum_hi       = 4'h0;
            return 1'b0;
        end

        case (rx_state)
            ST_BODY:
            begin
                if (c == CHAR_END)
                begin
                    rx_state = ST_SUM_HI;
                    return 1'b0;
                end
                frame_sum += c;
                if (c == CHAR_ESCAPE)
                begin
                    rx_state = ST_ESCAPE;
                    return 1'b0;
                end
                if (c == CHAR_RUN)
                begin
                    rx_state = ST_COUNT;
                    return 1'b0;
                end
                last_byte = c;
                return emit_copies(c, 1, r);
            end
            ST_ESCAPE:
            begin
                if (c == CHAR_END)
                begin
                    rx_state = ST_SUM_HI;
                    return 1'b0;
                end
                frame_sum += c;
                rx_state  = ST_BODY;
                last_byte = c ^ ESCAPE_XOR;
                return emit_copies(last_byte, 1, r);
            end
            ST_COUNT:
            begin
                if (c == CHAR_END)
                begin
                    rx_state = ST_SUM_HI;
                    return 1'b0;
                end
                frame_sum += c;
                rx_state = ST_BODY;
                if (c <= RUN_BIAS) return 1'b0;
                return emit_copies(last_byte, int'(c) - int'(RUN_BIAS), r);
            end
            ST_SUM_HI:
            begin
                nib        = hex_nibble(c);
                sum_hi_bad = (nib < 0);
                sum_hi     = (nib < 0) ? 4'h0 : 4'(nib);
                rx_state   = ST_SUM_LO;
                return 1'b0;
            end
            ST_SUM_LO:
            begin
                nib      = hex_nibble(c);
                mismatch = sum_hi_bad || (nib < 0) || ({sum_hi, 4'(nib)} != frame_sum);
                rx_state = ST_HUNT;
                r.length = 11'(decoded_len);
                if (no_ack)
                    r.kind = len_overflow ? KIND_OVERFLOW : KIND_ACCEPT;
                else if (mismatch)
                begin
                    r.kind  = KIND_BAD_SUM;
                    r.reply = REPLY_NAK;
                end
                else
                begin
                    r.kind  = len_overflow ? KIND_OVERFLOW : KIND_ACCEPT;
                    r.reply = REPLY_ACK;
                end
                return 1'b1;
            end
            default:
            begin
                // between packets only ack and nak matter
                rx_state = ST_HUNT;
                if (c == CHAR_ACK)
                begin
                    r.kind = KIND_ACK;
                    return 1'b1;
                end
                if (c == CHAR_NAK)
                begin
                    r.kind = KIND_NAK;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin : watch
        deframe_result_t want;
        deframe_result_t fresh;
        if (!rst_n)
        begin
            rx_state     = ST_HUNT;
            frame_sum    = 8'h00;
            decoded_len  = 0;
            len_overflow = 1'b0;
            last_byte    = 8'h00;
            sum_hi       = 4'h0;
            sum_hi_bad   = 1'b0;
            no_ack       = 1'b0;
            pending_results.delete();
            results_owed <= 0;
        end
        else
        begin
            // result transaction against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result: kind %0d data %02h",
                                              kind, data_byte));
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
                    if (data_byte !== want.data)
                        report_mismatch($sformatf("data_byte %02h, want %02h",
                                                  data_byte, want.data));
                    if (repeat_count !== want.copies)
                        report_mismatch($sformatf("repeat_count %0d, want %0d",
                                                  repeat_count, want.copies));
                    if (packet_length !== want.length)
                        report_mismatch($sformatf("packet_length %0d, want %0d",
                                                  packet_length, want.length));
                    if (reply !== want.reply)
                        report_mismatch($sformatf("reply %0d, want %0d", reply, want.reply));
                end
            end

            if (cfg_we)
                no_ack = cfg_wdata;

            // input transaction
            if (in_valid && !in_stall)
            begin
                if (decode_rx_byte(rx_byte, fresh))
                    pending_results.push_back(fresh);
            end

            results_owed <= pending_results.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench: stimulus and verdict for the debug packet deframer
// Feeds framed packets with escapes, runs, good and bad checksums, overflow
// sized bodies, broken frames and line noise, under random idling on both
// channels and one long output hold-off. A separate module predicts and
// checks every result; this top only drives the block and gives the verdict.
// ============================================================================
module testbench;
    import dpd_pkg::*;

    localparam int IDLE_PCT      = 14;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 64;
    localparam int CALM_FROM     = 600;
    localparam int CALM_TO       = 800;
    localparam int PHASE_BYTES   = 320;
    localparam int SETTLE_CYCLES = QUEUE_DEPTH_DEF + 6;
    localparam int CYCLE_LIMIT   = 200000;

    typedef enum {SUM_GOOD, SUM_WRONG, SUM_BAD_DIGIT} sum_mode_t;
    typedef logic [7:0] byte_q_t[$];

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  repeat_count;
    logic [10:0] packet_length;
    logic [1:0]  reply;

    int fail_count;
    int results_owed;
    int bytes_sent = 0;
    int cycles     = 0;
    bit calm       = 1'b0;

    debug_packet_deframer_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .data_byte     (data_byte),
        .repeat_count  (repeat_count),
        .packet_length (packet_length),
        .reply         (reply)
    );

    deframer_check #(
        .CAPACITY (PACKET_CAPACITY_DEF)
    ) scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .data_byte     (data_byte),
        .repeat_count  (repeat_count),
        .packet_length (packet_length),
        .reply         (reply),
        .fail_count    (fail_count),
        .results_owed  (results_owed)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off so the input backs up
    initial
    begin : receiver
        bit held_done;
        held_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_done && bytes_sent >= HOLD_AT)
            begin
                held_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Hex digit, random letter case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + {4'h0, n};
        return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
               (c >= "A" && c <= "F") || c == CHAR_START);
        return c;
    endfunction

    // Line noise between packets, heavy on ack and nak
    function automatic logic [7:0] noise_byte();
        logic [7:0] c;
        case ($urandom_range(4))
            0: c = CHAR_ACK;
            1: c = CHAR_NAK;
            default:
                do
                    c = 8'($urandom_range(255));
                while (c == CHAR_START);
        endcase
        return c;
    endfunction

    // Encoded body: literals, escapes and runs; big bodies lean on long runs
    function automatic byte_q_t random_body(input bit big);
        byte_q_t    q;
        int         tokens;
        int         sel;
        logic [7:0] c;
        tokens = big ? $urandom_range(6, 12) : $urandom_range(0, 10);
        repeat (tokens)
        begin
            sel = $urandom_range(99);
            if (big && sel < 60)
            begin
                q.push_back(CHAR_RUN);
                q.push_back(8'($urandom_range(200, 255)));
            end
            else if (sel < 55)
            begin
                do
                    c = 8'($urandom_range(255));
                while (c inside {CHAR_START, CHAR_END, CHAR_ESCAPE, CHAR_RUN});
                q.push_back(c);
            end
            else if (sel < 75)
            begin
                q.push_back(CHAR_ESCAPE);
                case ($urandom_range(7))
                    0: c = CHAR_START ^ ESCAPE_XOR;
                    1: c = CHAR_END ^ ESCAPE_XOR;
                    2: c = CHAR_ESCAPE ^ ESCAPE_XOR;
                    3: c = CHAR_RUN ^ ESCAPE_XOR;
                    default:
                        do
                            c = 8'($urandom_range(255));
                        while (c == CHAR_START || c == CHAR_END);
                endcase
                q.push_back(c);
            end
            else
            begin
                q.push_back(CHAR_RUN);
                if ($urandom_range(4) == 0)
                    c = 8'($urandom_range(0, 29));
                else
                    do
                        c = 8'($urandom_range(30, 255));
                    while (c == CHAR_START || c == CHAR_END);
                q.push_back(c);
            end
        end
        return q;
    endfunction

    // One byte transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        calm = (bytes_sent >= CALM_FROM && bytes_sent < CALM_TO);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // Full frame: start, body, end and two checksum digits
    task automatic send_frame(input byte_q_t body, input sum_mode_t mode);
        logic [7:0] sum;
        logic [7:0] hi_c;
        logic [7:0] lo_c;
        sum = 8'h00;
        foreach (body[i]) sum += body[i];
        if (mode == SUM_WRONG) sum ^= 8'($urandom_range(1, 255));
        hi_c = hex_char(sum[7:4]);
        lo_c = hex_char(sum[3:0]);
        if (mode == SUM_BAD_DIGIT)
        begin
            if ($urandom_range(1)) hi_c = non_hex_char();
            else                   lo_c = non_hex_char();
        end
        send_byte(CHAR_START);
        foreach (body[i]) send_byte(body[i]);
        send_byte(CHAR_END);
        send_byte(hi_c);
        send_byte(lo_c);
    endtask

    // Stop offering bytes and let every owed result come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_no_ack(input logic mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly clean frames; the rest noise, cut-off frames and raw bytes
    task automatic run_random(input int target);
        int        pick;
        int        cut;
        byte_q_t   body;
        sum_mode_t mode;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 72)
            begin
                case ($urandom_range(9))
                    8:       mode = SUM_WRONG;
                    9:       mode = SUM_BAD_DIGIT;
                    default: mode = SUM_GOOD;
                endcase
                send_frame(random_body($urandom_range(14) == 0), mode);
            end
            else if (pick < 82)
                repeat ($urandom_range(1, 6)) send_byte(noise_byte());
            else if (pick < 92)
            begin
                // frame cut short, sometimes restarted on the spot
                body = random_body(1'b0);
                cut  = $urandom_range(body.size());
                send_byte(CHAR_START);
                for (int i = 0; i < cut; i++) send_byte(body[i]);
                if ($urandom_range(2) == 0) send_byte(CHAR_START);
            end
            else
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
        end
    endtask

    // Main sequence
    initial
    begin : stimulus
        byte_q_t body;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_no_ack(1'b0);

        // ack and nak between packets
        send_byte(CHAR_ACK);
        send_byte(CHAR_NAK);
        // longest run at packet start, escaped escape, empty run at the bias,
        // byte extremes, ack character as payload
        body = {CHAR_RUN, 8'hFF, CHAR_ESCAPE, 8'h5D, CHAR_RUN, 8'h1D,
                8'hFF, 8'h00, CHAR_ACK};
        send_frame(body, SUM_GOOD);
        // restart mid packet, then end character right after an escape
        send_byte(CHAR_START);
        send_byte(8'h41);
        body = {CHAR_ESCAPE};
        send_frame(body, SUM_GOOD);
        // end character in place of a count, then a non-hex digit
        body = {CHAR_RUN};
        send_frame(body, SUM_BAD_DIGIT);
        settle();

        // random phases, alternating the no-ack setting
        set_no_ack(1'b1);
        run_random(bytes_sent + PHASE_BYTES);
        settle();
        set_no_ack(1'b0);
        run_random(bytes_sent + PHASE_BYTES);
        settle();
        set_no_ack(1'b1);
        run_random(bytes_sent + PHASE_BYTES);
        settle();
        set_no_ack(1'b0);
        run_random(bytes_sent + PHASE_BYTES);
        settle();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
